@@ hdl/skvt_pkg.sv @@
// shared types, constants and codes for the sorted key/value table
package skvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int POS_BITS   = 7;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_GET    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } skvt_req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_FULL      = 2'd3
    } skvt_status_t;

    // what follows the search for the current request
    typedef enum logic [2:0] {
        ACT_DONE,
        ACT_UP,
        ACT_INS,
        ACT_GET,
        ACT_DN,
        ACT_DEL
    } skvt_act_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key;
        logic [31:0] value;
    } skvt_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [6:0]  position;
    } skvt_rsp_t;

    typedef struct packed {
        logic load;
        logic probe;
        logic cmp;
        logic act;
        logic up_wr;
        logic ins;
        logic dn_wr;
        logic del;
        logic get;
    } skvt_cmd_t;

    typedef struct packed {
        logic      is_clear;
        logic      lo_lt_hi;
        logic      cmp_eq;
        skvt_act_t act;
        logic      up_more;
        logic      dn_more;
    } skvt_stat_t;

endpackage

@@ hdl/skvt_datapath.sv @@
// table memories, search bounds, shift index, entry count and result registers
module skvt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  skvt_pkg::skvt_req_t  req,
    input  skvt_pkg::skvt_cmd_t  cmd,
    output skvt_pkg::skvt_stat_t stat,
    output skvt_pkg::skvt_rsp_t  rsp
);

    logic [skvt_pkg::KEY_BITS-1:0]   key_mem [skvt_pkg::CAPACITY];
    logic [skvt_pkg::VALUE_BITS-1:0] val_mem [skvt_pkg::CAPACITY];
    logic [skvt_pkg::KEY_BITS-1:0]   key_q_reg;
    logic [skvt_pkg::VALUE_BITS-1:0] val_q_reg;

    logic [1:0]                      type_reg;
    logic [skvt_pkg::KEY_BITS-1:0]   key_reg;
    logic [skvt_pkg::VALUE_BITS-1:0] value_reg;
    logic [skvt_pkg::CNT_BITS-1:0]   lo_reg;
    logic [skvt_pkg::CNT_BITS-1:0]   hi_reg;
    logic [skvt_pkg::CNT_BITS-1:0]   mid_reg;
    logic [skvt_pkg::CNT_BITS-1:0]   pos_reg;
    logic [skvt_pkg::CNT_BITS-1:0]   idx_reg;
    logic [skvt_pkg::CNT_BITS-1:0]   cnt_reg;
    logic                            hit_reg;
    skvt_pkg::skvt_rsp_t             rsp_reg;

    logic [skvt_pkg::CNT_BITS:0]     mid_sum;
    logic [skvt_pkg::CNT_BITS-1:0]   mid;
    logic [skvt_pkg::CNT_BITS:0]     pos_p1;
    logic [skvt_pkg::CNT_BITS:0]     idx_p2;
    logic [skvt_pkg::CNT_BITS-1:0]   rd_ptr;
    logic [skvt_pkg::CNT_BITS-1:0]   wr_ptr;
    logic                            wr_en;
    logic [skvt_pkg::KEY_BITS-1:0]   wr_key;
    logic [skvt_pkg::VALUE_BITS-1:0] wr_val;
    skvt_pkg::skvt_act_t             act;
    skvt_pkg::skvt_status_t          miss_status;

    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = mid_sum[skvt_pkg::CNT_BITS:1];
        pos_p1  = {1'b0, pos_reg} + 1'b1;
        idx_p2  = {1'b0, idx_reg} + 2'd2;

        act         = skvt_pkg::ACT_DONE;
        miss_status = skvt_pkg::ST_OK;
        case (skvt_pkg::skvt_req_type_t'(type_reg))
            skvt_pkg::REQ_SET:
            begin
                if (!hit_reg)
                begin
                    if (cnt_reg >= skvt_pkg::CNT_BITS'(skvt_pkg::CAPACITY))
                        miss_status = skvt_pkg::ST_FULL;
                    else if (cnt_reg > pos_reg)
                        act = skvt_pkg::ACT_UP;
                    else
                        act = skvt_pkg::ACT_INS;
                end
            end
            skvt_pkg::REQ_GET:
            begin
                if (hit_reg)
                    act = skvt_pkg::ACT_GET;
                else
                    miss_status = skvt_pkg::ST_NOT_FOUND;
            end
            skvt_pkg::REQ_REMOVE:
            begin
                if (!hit_reg)
                    miss_status = skvt_pkg::ST_ABSENT;
                else if (pos_p1 < {1'b0, cnt_reg})
                    act = skvt_pkg::ACT_DN;
                else
                    act = skvt_pkg::ACT_DEL;
            end
            default:
            begin
                act = skvt_pkg::ACT_DONE;
            end
        endcase

        // read port address: data is used only in the cycle after
        rd_ptr = idx_p2[skvt_pkg::CNT_BITS-1:0];
        if (cmd.probe)
            rd_ptr = mid;
        else if (cmd.act && act == skvt_pkg::ACT_UP)
            rd_ptr = cnt_reg - 1'b1;
        else if (cmd.act && act == skvt_pkg::ACT_GET)
            rd_ptr = pos_reg;
        else if (cmd.act && act == skvt_pkg::ACT_DN)
            rd_ptr = pos_p1[skvt_pkg::CNT_BITS-1:0];
        else if (cmd.up_wr)
            rd_ptr = idx_reg - 2'd2;

        wr_en  = 1'b0;
        wr_ptr = pos_reg;
        wr_key = key_reg;
        wr_val = value_reg;
        if (cmd.act && act == skvt_pkg::ACT_DONE && hit_reg &&
            type_reg == skvt_pkg::REQ_SET)
            wr_en = 1'b1;
        else if (cmd.ins)
            wr_en = 1'b1;
        else if (cmd.up_wr || cmd.dn_wr)
        begin
            wr_en  = 1'b1;
            wr_ptr = idx_reg;
            wr_key = key_q_reg;
            wr_val = val_q_reg;
        end

        stat.is_clear = (req.req_type == skvt_pkg::REQ_CLEAR);
        stat.lo_lt_hi = (lo_reg < hi_reg);
        stat.cmp_eq   = (key_q_reg == key_reg);
        stat.act      = act;
        stat.up_more  = (idx_reg > pos_p1[skvt_pkg::CNT_BITS-1:0]) &&
                        (pos_p1 < {1'b0, idx_reg});
        stat.dn_more  = (idx_p2 < {1'b0, cnt_reg});
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_ptr[skvt_pkg::IDX_BITS-1:0]] <= wr_key;
            val_mem[wr_ptr[skvt_pkg::IDX_BITS-1:0]] <= wr_val;
        end
        key_q_reg <= key_mem[rd_ptr[skvt_pkg::IDX_BITS-1:0]];
        val_q_reg <= val_mem[rd_ptr[skvt_pkg::IDX_BITS-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load && req.req_type == skvt_pkg::REQ_CLEAR)
            cnt_reg <= '0;
        else if (cmd.ins)
            cnt_reg <= cnt_reg + 1'b1;
        else if (cmd.del)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= req.req_type;
            key_reg   <= skvt_pkg::KEY_BITS'(req.key);
            value_reg <= skvt_pkg::VALUE_BITS'(req.value);
            lo_reg    <= '0;
            hi_reg    <= cnt_reg;
            hit_reg   <= 1'b0;
            rsp_reg   <= '{status: skvt_pkg::ST_OK, value_out: '0, position: '0};
        end
        if (cmd.probe)
        begin
            if (lo_reg < hi_reg)
                mid_reg <= mid;
            else
                pos_reg <= lo_reg;
        end
        if (cmd.cmp)
        begin
            if (key_q_reg == key_reg)
            begin
                hit_reg <= 1'b1;
                pos_reg <= mid_reg;
            end
            else if (key_q_reg > key_reg)
                lo_reg <= mid_reg + 1'b1;
            else
                hi_reg <= mid_reg;
        end
        if (cmd.act)
        begin
            if (act == skvt_pkg::ACT_UP)
                idx_reg <= cnt_reg;
            else if (act == skvt_pkg::ACT_DN)
                idx_reg <= pos_reg;
            rsp_reg <= '{status: miss_status, value_out: '0,
                         position: skvt_pkg::POS_BITS'(pos_reg)};
        end
        if (cmd.up_wr)
            idx_reg <= idx_reg - 1'b1;
        if (cmd.dn_wr)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.ins || cmd.del)
            rsp_reg <= '{status: skvt_pkg::ST_OK, value_out: '0,
                         position: skvt_pkg::POS_BITS'(pos_reg)};
        if (cmd.get)
            rsp_reg <= '{status: skvt_pkg::ST_OK, value_out: 32'(val_q_reg),
                         position: skvt_pkg::POS_BITS'(pos_reg)};
    end

    assign rsp = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= skvt_pkg::CNT_BITS'(skvt_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not grow the table");

    a_up_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.up_wr |-> idx_reg > pos_reg)
        else $error("shift up reached the insert position");

    a_dn_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dn_wr |-> ({1'b0, idx_reg} + 1'b1) < {1'b0, cnt_reg})
        else $error("shift down past the last entry");

endmodule

@@ hdl/skvt_ctrl.sv @@
// request sequencer: search probes, shift loops and result strobe
module skvt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  skvt_pkg::skvt_stat_t stat,
    output skvt_pkg::skvt_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_ACT,
        S_UP_WR,
        S_INS,
        S_DN_WR,
        S_DEL,
        S_GET
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd       = '0;
        cmd.load  = (state_reg == S_IDLE) && start;
        cmd.probe = (state_reg == S_PROBE);
        cmd.cmp   = (state_reg == S_CMP);
        cmd.act   = (state_reg == S_ACT);
        cmd.up_wr = (state_reg == S_UP_WR);
        cmd.ins   = (state_reg == S_INS);
        cmd.dn_wr = (state_reg == S_DN_WR);
        cmd.del   = (state_reg == S_DEL);
        cmd.get   = (state_reg == S_GET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (stat.is_clear)
                            done_reg <= 1'b1;
                        else
                        begin
                            state_reg <= S_PROBE;
                            busy_reg  <= 1'b1;
                        end
                    end
                end
                S_PROBE:
                begin
                    state_reg <= stat.lo_lt_hi ? S_CMP : S_ACT;
                end
                S_CMP:
                begin
                    state_reg <= stat.cmp_eq ? S_ACT : S_PROBE;
                end
                S_ACT:
                begin
                    case (stat.act)
                        skvt_pkg::ACT_UP:  state_reg <= S_UP_WR;
                        skvt_pkg::ACT_INS: state_reg <= S_INS;
                        skvt_pkg::ACT_GET: state_reg <= S_GET;
                        skvt_pkg::ACT_DN:  state_reg <= S_DN_WR;
                        skvt_pkg::ACT_DEL: state_reg <= S_DEL;
                        default:
                        begin
                            state_reg <= S_IDLE;
                            busy_reg  <= 1'b0;
                            done_reg  <= 1'b1;
                        end
                    endcase
                end
                S_UP_WR:
                begin
                    if (!stat.up_more)
                        state_reg <= S_INS;
                end
                S_DN_WR:
                begin
                    if (!stat.dn_more)
                        state_reg <= S_DEL;
                end
                S_INS, S_DEL, S_GET:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd.load)
        else $error("request loaded while busy");

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins || cmd.del || cmd.get) |=> done_reg && !busy_reg)
        else $error("finished request gave no result");

endmodule

@@ hdl/sorted_key_value_table.sv @@
// sorted key/value table: binary search with shift insert and remove
// a clear needs no search; other requests make at most 7 key compares, and an insert or remove
// then moves up to 63 entries
// throughput: one request at a time; busy is high until the result strobe is set
// one memory read and one memory write per cycle set the shift rate
// reset empties the table at once; no clearing pass, the result strobe is low
module sorted_key_value_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  skvt_pkg::skvt_req_t req,
    output logic                busy,
    output logic                done,
    output skvt_pkg::skvt_rsp_t rsp
);

    skvt_pkg::skvt_cmd_t  cmd;
    skvt_pkg::skvt_stat_t stat;

    skvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    skvt_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

@@ tb/testbench.sv @@
// testbench for the sorted key/value table: directed table, random requests, result checks
module testbench;
    import skvt_pkg::*;

    localparam int ROWS     = 21;
    localparam int POOL     = 96;
    localparam int PER_PASS = 500;
    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] val;
        bit          typed;
        logic [1:0]  st;
        logic [31:0] vout;
        logic [6:0]  pos;
    } dir_row_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    skvt_req_t req   = '0;
    logic      busy;
    logic      done;
    skvt_rsp_t rsp;

    // predictor copy of the table
    logic [31:0] tbl_keys [CAPACITY];
    logic [31:0] tbl_vals [CAPACITY];
    int          tbl_count = 0;

    skvt_rsp_t   rsp_due [$];
    skvt_rsp_t   want_rsp;
    logic [31:0] key_pool [POOL];

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_full = 0;
    int n_hits = 0;
    int n_removed = 0;
    int n_clears = 0;
    int peak_count = 0;
    int quiet_cycles = 0;

    // directed requests; typed rows carry a hand-written expected response
    dir_row_t steps [ROWS] = '{
        '{REQ_GET,    32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 32'h0, 7'd0},
        '{REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_ABSENT,    32'h0, 7'd0},
        '{REQ_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK,        32'h0, 7'd0},
        '{REQ_SET,    32'h0000_0000, 32'h0000_0000, 1, ST_OK,        32'h0, 7'd1},
        '{REQ_SET,    32'h8000_0000, 32'h1234_5678, 1, ST_OK,        32'h0, 7'd1},
        '{REQ_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1, ST_OK,        32'hFFFF_FFFF, 7'd0},
        '{REQ_GET,    32'h0000_0000, 32'h0000_0000, 1, ST_OK,        32'h0, 7'd2},
        '{REQ_GET,    32'h7FFF_FFFF, 32'h0000_0000, 1, ST_NOT_FOUND, 32'h0, 7'd2},
        '{REQ_SET,    32'h8000_0001, 32'h55AA_55AA, 0, ST_OK,        32'h0, 7'd0},
        '{REQ_GET,    32'h8000_0001, 32'h0000_0000, 0, ST_OK,        32'h0, 7'd0},
        '{REQ_SET,    32'hFFFF_FFFF, 32'hA5A5_A5A5, 1, ST_OK,        32'h0, 7'd0},
        '{REQ_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1, ST_OK,        32'hA5A5_A5A5, 7'd0},
        '{REQ_REMOVE, 32'h8000_0000, 32'h0000_0000, 0, ST_OK,        32'h0, 7'd0},
        '{REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 0, ST_OK,        32'h0, 7'd0},
        '{REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, ST_ABSENT,    32'h0, 7'd2},
        '{REQ_GET,    32'h0000_0001, 32'hFFFF_FFFF, 0, ST_OK,        32'h0, 7'd0},
        '{REQ_CLEAR,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 1, ST_OK,        32'h0, 7'd0},
        '{REQ_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1, ST_NOT_FOUND, 32'h0, 7'd0},
        '{REQ_REMOVE, 32'h8000_0001, 32'h0000_0000, 1, ST_ABSENT,    32'h0, 7'd0},
        '{REQ_SET,    32'h5A5A_5A5A, 32'h0000_0000, 1, ST_OK,        32'h0, 7'd0},
        '{REQ_CLEAR,  32'h0000_0000, 32'h0000_0000, 1, ST_OK,        32'h0, 7'd0}
    };

    sorted_key_value_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
        $display("mismatch in %s at response %0d: got %h, expected %h",
                 what, n_checked, got, exp);
        n_errors++;
    endtask

    // binary search over the descending table; returns the hit or insert index
    function automatic logic [6:0] locate(input logic [31:0] k, output bit hit);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = tbl_count;
        hit = 1'b0;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (tbl_keys[mid] == k)
            begin
                hit = 1'b1;
                return 7'(mid);
            end
            if (tbl_keys[mid] > k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return 7'(lo);
    endfunction

    function automatic skvt_rsp_t table_response(input skvt_req_t r);
        skvt_rsp_t  o;
        bit         hit;
        logic [6:0] at;
        int         i;
        o   = '0;
        hit = 1'b0;
        at  = '0;
        if (r.req_type == REQ_CLEAR)
        begin
            tbl_count = 0;
            n_clears++;
        end
        else
        begin
            at = locate(r.key, hit);
            case (r.req_type)
                REQ_SET:
                begin
                    if (hit)
                        tbl_vals[at] = r.value;
                    else if (tbl_count >= CAPACITY)
                    begin
                        o.status = ST_FULL;
                        n_full++;
                    end
                    else
                    begin
                        for (i = tbl_count; i > at; i--)
                        begin
                            tbl_keys[i] = tbl_keys[i-1];
                            tbl_vals[i] = tbl_vals[i-1];
                        end
                        tbl_keys[at] = r.key;
                        tbl_vals[at] = r.value;
                        tbl_count++;
                        if (tbl_count > peak_count)
                            peak_count = tbl_count;
                    end
                end
                REQ_GET:
                begin
                    if (hit)
                    begin
                        o.value_out = tbl_vals[at];
                        n_hits++;
                    end
                    else
                        o.status = ST_NOT_FOUND;
                end
                default:
                begin
                    if (hit)
                    begin
                        for (i = at; i + 1 < tbl_count; i++)
                        begin
                            tbl_keys[i] = tbl_keys[i+1];
                            tbl_vals[i] = tbl_vals[i+1];
                        end
                        tbl_count--;
                        n_removed++;
                    end
                    else
                        o.status = ST_ABSENT;
                end
            endcase
        end
        o.position = at;
        return o;
    endfunction

    // present one request, optionally after a random gap, and wait for acceptance
    task automatic issue(input skvt_req_t r, input int idle_pct, input bit typed,
                         input skvt_rsp_t want);
        skvt_rsp_t calc;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        calc = table_response(r);
        rsp_due.push_back(typed ? want : calc);
        n_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rsp_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic skvt_req_t random_request(input int set_pct);
        skvt_req_t r;
        int        pick;
        r.value = $urandom();
        // mostly pooled keys so sets, gets and removes collide
        if ($urandom_range(99) < 85)
            r.key = key_pool[$urandom_range(POOL-1)];
        else
            r.key = $urandom();
        pick = $urandom_range(999);
        if (pick < 3)
            r.req_type = REQ_CLEAR;
        else if (pick < 3 + set_pct * 10)
            r.req_type = REQ_SET;
        else if ($urandom_range(99) < 60)
            r.req_type = REQ_GET;
        else
            r.req_type = REQ_REMOVE;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (rsp_due.size() == 0)
                note_mismatch("unrequested response", {30'h0, rsp.status}, 32'h0);
            else
            begin
                want_rsp = rsp_due.pop_front();
                if (rsp.status !== want_rsp.status)
                    note_mismatch("status", {30'h0, rsp.status}, {30'h0, want_rsp.status});
                if (rsp.value_out !== want_rsp.value_out)
                    note_mismatch("value_out", rsp.value_out, want_rsp.value_out);
                if (rsp.position !== want_rsp.position)
                    note_mismatch("position", {25'h0, rsp.position},
                                  {25'h0, want_rsp.position});
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no progress for %0d cycles, %0d responses pending",
                     STALL_LIMIT, rsp_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        skvt_req_t r;
        skvt_rsp_t w;
        int        idle_of [3];
        int        set_of [3];
        int        p;
        int        n;
        idle_of = '{0, 84, 30};
        set_of  = '{60, 40, 50};

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (n = 4; n < POOL; n++)
            key_pool[n] = $urandom();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < ROWS; n++)
        begin
            r.req_type  = steps[n].op;
            r.key       = steps[n].key;
            r.value     = steps[n].val;
            w.status    = steps[n].st;
            w.value_out = steps[n].vout;
            w.position  = steps[n].pos;
            issue(r, 0, steps[n].typed, w);
        end
        drain();

        for (p = 0; p < 3; p++)
        begin
            for (n = 0; n < PER_PASS; n++)
            begin
                // keep a burst with no gaps inside the idling passes
                issue(random_request(set_of[p]), (n % 100 < 20) ? 0 : idle_of[p], 1'b0, '0);
            end
            drain();
        end

        repeat (100) @(posedge clk);
        $display("%0d requests, %0d responses checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("%0d get hits, %0d removals, %0d table-full, %0d clears, peak %0d entries",
                 n_hits, n_removed, n_full, n_clears, peak_count);
        if (n_errors == 0 && rsp_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
